// ===== rtl/bounded_stack_with_dump_unit_assert.svh =====
// Assertion macros for the stack RTL
`ifndef BOUNDED_STACK_WITH_DUMP_UNIT_ASSERT_SVH
`define BOUNDED_STACK_WITH_DUMP_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BSD_ASSERT_HOLDS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("stack invariant violated");
`define BSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stack sequencing violated");
`else
`define BSD_ASSERT_HOLDS(label, clk, rst_n, prop)
`define BSD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/bsd_pkg.sv =====
// Shared types and constants for the bounded stack
package bsd_pkg;

    localparam int DEPTH      = 64;
    localparam int CAP_W      = 7;
    localparam int DATA_W     = 32;
    localparam logic [6:0] CAP_RESET = 7'd64;

    typedef enum logic [2:0] {
        OP_PUSH        = 3'd0,
        OP_POP         = 3'd1,
        OP_PEEK        = 3'd2,
        OP_LIST_TOP    = 3'd3,
        OP_LIST_BOTTOM = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LIST = 2'b10
    } t_state;

    localparam logic [1:0] REG_CAPACITY = 2'd0;

endpackage

// ===== rtl/bsd_store.sv =====
// Entry memory: one write port, one registered read port
module bsd_store #(
    parameter int DEPTH = bsd_pkg::DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [bsd_pkg::DATA_W-1:0] i_wr_data,
    input  logic                      i_rd_en,
    input  logic [AW-1:0]             i_rd_addr,
    output logic [bsd_pkg::DATA_W-1:0] o_rd_data
);

    logic [bsd_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [bsd_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/bounded_stack_with_dump_unit.sv =====
// Top level of the bounded LIFO stack with peek and list dump
// Usage:
//   Commands enter on start/i_operation/i_push_value and transfer at a clock edge
//   with start high and busy low. Push and pop emit nothing. Peek on a
//   non-empty stack emits one result in the cycle after the transfer, with
//   o_last_of_run set.
//   List top-first and list bottom-first emit one result per stored entry, the
//   first in the cycle after the transfer, then one per cycle; o_last_of_run
//   marks the final one. busy stays high after a list transfer until the final
//   entry has been read; other commands leave busy low.
//   The rate is set by the single read port of the entry memory, walked by one
//   address stepper under a two-state sequencer.
//   Results appear on o_entry_value/o_last_of_run for exactly one cycle, marked
//   by o_valid; the receiver cannot stall them.
//   The capacity register sits at APB address 0 (pready always high). Capacity
//   values above DEPTH act as DEPTH.
//   Reset (synchronous, active low) empties the stack, sets capacity to 64 and
//   returns the sequencer to idle. No clearing pass is needed.
module bounded_stack_with_dump_unit #(
    parameter int DEPTH = bsd_pkg::DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  i_operation,
    input  logic signed [31:0]          i_push_value,
    output logic                        o_valid,
    output logic signed [31:0]          o_entry_value,
    output logic                        o_last_of_run,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [1:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [bsd_pkg::CAP_W-1:0] DEPTH_CAP = bsd_pkg::CAP_W'(DEPTH);

    bsd_pkg::t_state            r_state, n_state;
    logic [CW-1:0]              r_fill, n_fill;
    logic [CW-1:0]              r_left, n_left;
    logic [AW-1:0]              r_addr, n_addr;
    logic                       r_dir, n_dir;
    logic                       r_rd_valid, n_rd_valid;
    logic                       r_rd_last, n_rd_last;
    logic [bsd_pkg::CAP_W-1:0]  r_capacity;

    logic                       accept;
    logic                       cfg_wr;
    logic [bsd_pkg::CAP_W-1:0]  limit;
    logic [CW-1:0]              fill_m1;
    logic [AW-1:0]              top_addr;
    logic [AW-1:0]              step_base, step_out;
    logic                       step_up;
    logic                       wr_en, rd_en;
    logic [AW-1:0]              rd_addr;
    logic [bsd_pkg::DATA_W-1:0] rd_data;

    assign busy    = (r_state != bsd_pkg::S_IDLE);
    assign accept  = start && !busy;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = (paddr == bsd_pkg::REG_CAPACITY) ? {25'd0, r_capacity} : 32'd0;

    assign limit    = (r_capacity > DEPTH_CAP) ? DEPTH_CAP : r_capacity;
    assign fill_m1  = r_fill - CW'(1);
    assign top_addr = fill_m1[AW-1:0];
    assign step_out = step_up ? (step_base + AW'(1)) : (step_base - AW'(1));

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_left     = r_left;
        n_addr     = r_addr;
        n_dir      = r_dir;
        n_rd_valid = 1'b0;
        n_rd_last  = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = r_addr;
        step_base  = r_addr;
        step_up    = r_dir;
        unique case (r_state)
            bsd_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (bsd_pkg::t_op'(i_operation))
                        bsd_pkg::OP_PUSH: begin
                            if (bsd_pkg::CAP_W'(r_fill) < limit) begin
                                wr_en  = 1'b1;
                                n_fill = r_fill + CW'(1);
                            end
                        end
                        bsd_pkg::OP_POP: begin
                            if (r_fill != '0) begin
                                n_fill = fill_m1;
                            end
                        end
                        bsd_pkg::OP_PEEK: begin
                            if (r_fill != '0) begin
                                rd_en      = 1'b1;
                                rd_addr    = top_addr;
                                n_rd_valid = 1'b1;
                                n_rd_last  = 1'b1;
                            end
                        end
                        bsd_pkg::OP_LIST_TOP: begin
                            if (r_fill != '0) begin
                                rd_en      = 1'b1;
                                rd_addr    = top_addr;
                                step_base  = top_addr;
                                step_up    = 1'b0;
                                n_addr     = step_out;
                                n_dir      = 1'b0;
                                n_left     = fill_m1;
                                n_rd_valid = 1'b1;
                                n_rd_last  = (r_fill == CW'(1));
                                if (r_fill != CW'(1)) begin
                                    n_state = bsd_pkg::S_LIST;
                                end
                            end
                        end
                        bsd_pkg::OP_LIST_BOTTOM: begin
                            if (r_fill != '0) begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                step_base  = '0;
                                step_up    = 1'b1;
                                n_addr     = step_out;
                                n_dir      = 1'b1;
                                n_left     = fill_m1;
                                n_rd_valid = 1'b1;
                                n_rd_last  = (r_fill == CW'(1));
                                if (r_fill != CW'(1)) begin
                                    n_state = bsd_pkg::S_LIST;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            bsd_pkg::S_LIST: begin
                rd_en      = 1'b1;
                rd_addr    = r_addr;
                n_addr     = step_out;
                n_left     = r_left - CW'(1);
                n_rd_valid = 1'b1;
                n_rd_last  = (r_left == CW'(1));
                if (r_left == CW'(1)) begin
                    n_state = bsd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bsd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bsd_pkg::S_IDLE;
            r_fill     <= '0;
            r_rd_valid <= 1'b0;
            r_capacity <= bsd_pkg::CAP_RESET;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_rd_valid <= n_rd_valid;
            if (cfg_wr && (paddr == bsd_pkg::REG_CAPACITY)) begin
                r_capacity <= pwdata[bsd_pkg::CAP_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_left    <= n_left;
        r_addr    <= n_addr;
        r_dir     <= n_dir;
        r_rd_last <= n_rd_last;
    end

    bsd_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_fill[AW-1:0]),
        .i_wr_data (i_push_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_valid       = r_rd_valid;
    assign o_entry_value = $signed(rd_data);
    assign o_last_of_run = r_rd_last;

`include "bounded_stack_with_dump_unit_assert.svh"

    `BSD_ASSERT_HOLDS(a_fill_bound, i_clk, i_rst_n, r_fill <= CW'(DEPTH))
    `BSD_ASSERT_HOLDS(a_list_left, i_clk, i_rst_n, (r_state != bsd_pkg::S_LIST) || (r_left != '0))
    `BSD_ASSERT_NEXT(a_list_end, i_clk, i_rst_n, (r_state == bsd_pkg::S_LIST) && (r_left == CW'(1)), (r_state == bsd_pkg::S_IDLE) && o_valid && o_last_of_run)
    `BSD_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, wr_en, r_fill == $past(r_fill) + CW'(1))

endmodule
